>>> sv/llars_pkg.sv
// Package for the life-like automaton row step: item types, register codes, sizes.
package llars_pkg;

  localparam int ROW_WIDTH = 64;
  localparam int COL_W     = 7;
  localparam int COUNT_W   = 4;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  // result queue, depth a power of two
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_BIRTH_COUNT = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_SURVIVE_MIN = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SURVIVE_MAX = CFG_INDEX_W'(3);

  localparam logic [COL_W-1:0]   GRID_WIDTH_RST  = COL_W'(64);
  localparam logic [COUNT_W-1:0] BIRTH_COUNT_RST = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] SURVIVE_MIN_RST = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] SURVIVE_MAX_RST = COUNT_W'(6);

  typedef struct packed {
    logic [ROW_WIDTH-1:0] row_cells;
    logic                 last_row;
  } in_item_t;

  typedef struct packed {
    logic [ROW_WIDTH-1:0] next_cells;
    logic                 frame_end;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] birth_count;
    logic [COUNT_W-1:0] survive_min;
    logic [COUNT_W-1:0] survive_max;
  } rule_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  first;
    out_item_t  second;
  } res_push_t;

endpackage

>>> sv/llars_next_row.sv
// Next-generation row from the rows above, at and below: neighbour counts and rule.
module llars_next_row (
  input  logic [llars_pkg::ROW_WIDTH-1:0] up,
  input  logic [llars_pkg::ROW_WIDTH-1:0] mid,
  input  logic [llars_pkg::ROW_WIDTH-1:0] down,
  input  llars_pkg::rule_t                rule,
  input  logic [llars_pkg::ROW_WIDTH-1:0] mask,
  output logic [llars_pkg::ROW_WIDTH-1:0] next_row
);

  logic [llars_pkg::ROW_WIDTH+1:0] up_p;
  logic [llars_pkg::ROW_WIDTH+1:0] mid_p;
  logic [llars_pkg::ROW_WIDTH+1:0] down_p;
  logic [llars_pkg::ROW_WIDTH-1:0] raw;

  // padded by a dead column on each side; column c sits at bit c+1
  assign up_p   = {1'b0, up, 1'b0};
  assign mid_p  = {1'b0, mid, 1'b0};
  assign down_p = {1'b0, down, 1'b0};

  always_comb begin
    logic [llars_pkg::COUNT_W-1:0] cnt;
    raw = '0;
    cnt = '0;
    for (int c = 0; c < llars_pkg::ROW_WIDTH; c++) begin
      cnt = llars_pkg::COUNT_W'(up_p[c]) + llars_pkg::COUNT_W'(up_p[c+1])
          + llars_pkg::COUNT_W'(up_p[c+2]) + llars_pkg::COUNT_W'(mid_p[c])
          + llars_pkg::COUNT_W'(mid_p[c+2]) + llars_pkg::COUNT_W'(down_p[c])
          + llars_pkg::COUNT_W'(down_p[c+1]) + llars_pkg::COUNT_W'(down_p[c+2]);
      if (mid_p[c+1]) begin
        raw[c] = (cnt >= rule.survive_min) && (cnt <= rule.survive_max);
      end else begin
        raw[c] = (cnt == rule.birth_count);
      end
    end
  end

  assign next_row = raw & mask;

endmodule

>>> sv/llars_res_fifo.sv
// Small result queue: takes up to two items a cycle, gives one while out_stall is low.
module llars_res_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  llars_pkg::res_push_t             push,
  output logic [llars_pkg::RES_CNT_W-1:0]  space,
  output logic                             out_valid,
  input  logic                             out_stall,
  output llars_pkg::out_item_t             out_item
);

  llars_pkg::out_item_t              mem [llars_pkg::RES_DEPTH];
  logic [llars_pkg::RES_PTR_W-1:0]   wr_ptr;
  logic [llars_pkg::RES_PTR_W-1:0]   rd_ptr;
  logic [llars_pkg::RES_CNT_W-1:0]   count;
  logic                              pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign space     = llars_pkg::RES_CNT_W'(llars_pkg::RES_DEPTH) - count;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + llars_pkg::RES_PTR_W'(push.n);
      rd_ptr <= rd_ptr + llars_pkg::RES_PTR_W'(pop);
      count  <= count + llars_pkg::RES_CNT_W'(push.n) - llars_pkg::RES_CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + llars_pkg::RES_CNT_W'($past(push.n))
                      - llars_pkg::RES_CNT_W'($past(pop)))
    else $error("result queue count lost track");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    llars_pkg::RES_CNT_W'(push.n) <= space)
    else $error("result queue overflow");
`endif

endmodule

>>> sv/life_like_automaton_row_step_top.sv
// Top level of the life-like automaton row step.
//
// Rows of the current generation enter on the input channel (in_valid, in_stall,
// in_item), top to bottom, the bottom row flagged by last_row. Next-generation
// rows leave on the output channel (out_valid, out_stall, out_item); frame_end
// marks the bottom row. A row's result leaves once the row below it has entered;
// the bottom row gives two items, its upper neighbour and itself, or one in a one-row grid.
// An item is registered in the input register, then processed into the
// four-entry result queue once the queue has room for its results. One row is
// taken every cycle while in_stall is low; the result queue drains one item a
// cycle while out_stall is low, so each bottom row adds one item to the output.
// in_stall rises only when the processing stage holds an item that the queue has
// no room for; a stalled receiver therefore backs up into the input after the
// queue fills, and nothing is lost.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// unknown indexes are ignored. Write only while the block is idle.
// Reset (rst, synchronous) restores the B4/S3456 rule, width 64, and an empty
// row buffer, and empties the queue.
module life_like_automaton_row_step_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  llars_pkg::in_item_t                 in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output llars_pkg::out_item_t                out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [llars_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [llars_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [llars_pkg::COL_W-1:0]      grid_width;
  llars_pkg::rule_t                 rule;
  logic [llars_pkg::ROW_WIDTH-1:0]  mask;

  logic                             s_valid;
  logic [llars_pkg::ROW_WIDTH-1:0]  s_row;
  logic                             s_last;
  logic [llars_pkg::ROW_WIDTH-1:0]  row_m;

  logic [llars_pkg::ROW_WIDTH-1:0]  above;
  logic [llars_pkg::ROW_WIDTH-1:0]  centre;
  logic                             have_centre;

  logic [llars_pkg::ROW_WIDTH-1:0]  res_mid;
  logic [llars_pkg::ROW_WIDTH-1:0]  res_bot;
  logic [1:0]                       n_res;
  logic                             s_go;
  logic                             in_take;
  logic [llars_pkg::RES_CNT_W-1:0]  space;
  llars_pkg::res_push_t             push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width       <= llars_pkg::GRID_WIDTH_RST;
      rule.birth_count <= llars_pkg::BIRTH_COUNT_RST;
      rule.survive_min <= llars_pkg::SURVIVE_MIN_RST;
      rule.survive_max <= llars_pkg::SURVIVE_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        llars_pkg::REG_GRID_WIDTH:  grid_width <= cfg_data[llars_pkg::COL_W-1:0];
        llars_pkg::REG_BIRTH_COUNT: rule.birth_count <= cfg_data[llars_pkg::COUNT_W-1:0];
        llars_pkg::REG_SURVIVE_MIN: rule.survive_min <= cfg_data[llars_pkg::COUNT_W-1:0];
        llars_pkg::REG_SURVIVE_MAX: rule.survive_max <= cfg_data[llars_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // active columns; widths above the row saturate
  always_comb begin
    for (int c = 0; c < llars_pkg::ROW_WIDTH; c++) begin
      mask[c] = (llars_pkg::COL_W'(c) < grid_width);
    end
  end

  // input register
  assign in_take  = in_valid && !in_stall;
  assign in_stall = s_valid && !s_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_take) begin
      s_valid <= 1'b1;
    end else if (s_go) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_row  <= in_item.row_cells;
      s_last <= in_item.last_row;
    end
  end

  // processing stage
  assign row_m = s_row & mask;
  assign n_res = {1'b0, have_centre} + {1'b0, s_last};
  assign s_go  = s_valid && (llars_pkg::RES_CNT_W'(n_res) <= space);

  // centre is all dead when no row is held, so it doubles as the row above
  llars_next_row u_mid (
    .up       (above),
    .mid      (centre),
    .down     (row_m),
    .rule     (rule),
    .mask     (mask),
    .next_row (res_mid)
  );

  llars_next_row u_bot (
    .up       (centre),
    .mid      (row_m),
    .down     ('0),
    .rule     (rule),
    .mask     (mask),
    .next_row (res_bot)
  );

  always_comb begin
    push.n                 = s_go ? n_res : 2'd0;
    push.second.next_cells = res_bot;
    push.second.frame_end  = 1'b1;
    if (have_centre) begin
      push.first.next_cells = res_mid;
      push.first.frame_end  = 1'b0;
    end else begin
      push.first.next_cells = res_bot;
      push.first.frame_end  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      above       <= '0;
      centre      <= '0;
      have_centre <= 1'b0;
    end else if (s_go) begin
      if (s_last) begin
        above       <= '0;
        centre      <= '0;
        have_centre <= 1'b0;
      end else begin
        above       <= centre;
        centre      <= row_m;
        have_centre <= 1'b1;
      end
    end
  end

  llars_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    (s_go && s_last) |=> (!have_centre && centre == '0 && above == '0))
    else $error("row buffer not cleared after bottom row");
  a_row_held: assert property (@(posedge clk) disable iff (rst)
    (s_go && !s_last) |=> have_centre)
    else $error("row not held after a non-bottom row");
  a_empty_above: assert property (@(posedge clk) disable iff (rst)
    !have_centre |-> (centre == '0 && above == '0))
    else $error("stale rows with empty buffer");
`endif

endmodule

>>> sim/life_like_automaton_row_step_top_test.sv
// Self-checking testbench for the life-like automaton row step: rule and width settings, random grids.
`timescale 1ns / 1ps

module life_like_automaton_row_step_top_test;

  localparam logic [llars_pkg::CFG_INDEX_W-1:0] NO_SUCH_REG_LOW  = llars_pkg::CFG_INDEX_W'(4);
  localparam logic [llars_pkg::CFG_INDEX_W-1:0] NO_SUCH_REG_HIGH = '1;

  // holds the predicted next generation and checks rows leaving the block
  class next_gen_board;
    logic [llars_pkg::ROW_WIDTH-1:0] above;
    logic [llars_pkg::ROW_WIDTH-1:0] centre;
    logic [1:0]                      held;
    logic [llars_pkg::COL_W-1:0]     width;
    logic [llars_pkg::COUNT_W-1:0]   birth;
    logic [llars_pkg::COUNT_W-1:0]   surv_lo;
    logic [llars_pkg::COUNT_W-1:0]   surv_hi;
    llars_pkg::out_item_t            pending_rows[$];
    int                              errors;

    function new();
      width   = llars_pkg::GRID_WIDTH_RST;
      birth   = llars_pkg::BIRTH_COUNT_RST;
      surv_lo = llars_pkg::SURVIVE_MIN_RST;
      surv_hi = llars_pkg::SURVIVE_MAX_RST;
      above   = '0;
      centre  = '0;
      held    = '0;
      errors  = 0;
    endfunction

    function logic [llars_pkg::ROW_WIDTH-1:0] live_mask();
      if (int'(width) >= llars_pkg::ROW_WIDTH) return '1;
      return (llars_pkg::ROW_WIDTH'(1) << width) - 1'b1;
    endfunction

    function logic [llars_pkg::ROW_WIDTH-1:0] evolve(
        logic [llars_pkg::ROW_WIDTH-1:0] up, logic [llars_pkg::ROW_WIDTH-1:0] mid,
        logic [llars_pkg::ROW_WIDTH-1:0] down);
      logic [llars_pkg::ROW_WIDTH-1:0] res;
      int cnt;
      int col;
      res = '0;
      for (int c = 0; c < llars_pkg::ROW_WIDTH; c++) begin
        cnt = 0;
        for (int d = -1; d <= 1; d++) begin
          col = c + d;
          if (col >= 0 && col < llars_pkg::ROW_WIDTH) begin
            cnt += int'(up[col]) + int'(down[col]);
            if (d != 0) cnt += int'(mid[col]);
          end
        end
        if (mid[c])
          res[c] = (cnt >= int'(surv_lo)) && (cnt <= int'(surv_hi));
        else
          res[c] = (cnt == int'(birth));
      end
      return res & live_mask();
    endfunction

    function void note_reg(logic [llars_pkg::CFG_INDEX_W-1:0] idx,
                           logic [llars_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        llars_pkg::REG_GRID_WIDTH:  width   = data[llars_pkg::COL_W-1:0];
        llars_pkg::REG_BIRTH_COUNT: birth   = data[llars_pkg::COUNT_W-1:0];
        llars_pkg::REG_SURVIVE_MIN: surv_lo = data[llars_pkg::COUNT_W-1:0];
        llars_pkg::REG_SURVIVE_MAX: surv_hi = data[llars_pkg::COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_row(llars_pkg::in_item_t it);
      logic [llars_pkg::ROW_WIDTH-1:0] row;
      llars_pkg::out_item_t e;
      row = it.row_cells & live_mask();
      if (held != 0) begin
        e.next_cells = evolve(above, centre, row);
        e.frame_end  = 1'b0;
        pending_rows.push_back(e);
        above = centre;
        held  = 2'd2;
      end else begin
        above = '0;
        held  = 2'd1;
      end
      centre = row;
      if (it.last_row) begin
        e.next_cells = evolve(above, centre, '0);
        e.frame_end  = 1'b1;
        pending_rows.push_back(e);
        above  = '0;
        centre = '0;
        held   = '0;
      end
    endfunction

    function void check_next_row(llars_pkg::out_item_t got);
      llars_pkg::out_item_t e;
      if (pending_rows.size() == 0) begin
        $error("unexpected item: next_cells %h frame_end %b", got.next_cells, got.frame_end);
        errors++;
        return;
      end
      e = pending_rows.pop_front();
      if (got.next_cells !== e.next_cells) begin
        $error("next_cells: expected %h, actual %h", e.next_cells, got.next_cells);
        errors++;
      end
      if (got.frame_end !== e.frame_end) begin
        $error("frame_end: expected %b, actual %b", e.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  llars_pkg::in_item_t               in_item = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  llars_pkg::out_item_t              out_item;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [llars_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [llars_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  next_gen_board board = new();
  bit gaps_on  = 1'b0;
  bit stall_on = 1'b0;
  int stall_left = 0;
  int rows_sent = 0;

  life_like_automaton_row_step_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.note_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) board.take_row(in_item);
      if (out_valid && !out_stall) board.check_next_row(out_item);
    end
  end

  // receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // called and returns at a falling edge
  task automatic send_row(input logic [llars_pkg::ROW_WIDTH-1:0] cells, input logic last);
    llars_pkg::in_item_t it;
    it.row_cells = cells;
    it.last_row  = last;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    rows_sent++;
    @(negedge clk);
  endtask

  // sender holds off until every predicted row has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_rows.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_reg(input logic [llars_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [llars_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [llars_pkg::ROW_WIDTH-1:0] cells;
    int height;
    int lo;
    bit late;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    gaps_on  = 1'b1;
    stall_on = 1'b1;

    // single-row grid, then a grid of extreme rows under the default rule
    send_row('1, 1'b1);
    send_row('0, 1'b0);
    send_row('1, 1'b0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b0);
    send_row('1, 1'b1);
    settle();

    // no active column
    set_reg(llars_pkg::REG_GRID_WIDTH, llars_pkg::CFG_DATA_W'(0));
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    settle();

    // one column, birth on an empty neighbourhood
    set_reg(llars_pkg::REG_GRID_WIDTH, llars_pkg::CFG_DATA_W'(1));
    set_reg(llars_pkg::REG_BIRTH_COUNT, llars_pkg::CFG_DATA_W'(0));
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row('1, 1'b1);
    settle();

    // width beyond the row saturates; birth on a full neighbourhood, everything survives
    set_reg(llars_pkg::REG_GRID_WIDTH, '1);
    set_reg(llars_pkg::REG_BIRTH_COUNT, llars_pkg::CFG_DATA_W'(8));
    set_reg(llars_pkg::REG_SURVIVE_MIN, llars_pkg::CFG_DATA_W'(0));
    set_reg(llars_pkg::REG_SURVIVE_MAX, llars_pkg::CFG_DATA_W'(8));
    send_row('1, 1'b0);
    send_row(64'h00FF_00FF_00FF_00FF, 1'b0);
    send_row('1, 1'b1);
    settle();

    // unreachable birth, inverted survive bounds, unknown indexes
    set_reg(llars_pkg::REG_GRID_WIDTH, llars_pkg::CFG_DATA_W'(65));
    set_reg(llars_pkg::REG_BIRTH_COUNT, '1);
    set_reg(llars_pkg::REG_SURVIVE_MIN, 8'hF7);
    set_reg(llars_pkg::REG_SURVIVE_MAX, llars_pkg::CFG_DATA_W'(2));
    set_reg(NO_SUCH_REG_LOW, llars_pkg::CFG_DATA_W'(1));
    set_reg(NO_SUCH_REG_HIGH, '0);
    send_row({$urandom, $urandom}, 1'b0);
    send_row({$urandom, $urandom}, 1'b0);
    send_row({$urandom, $urandom}, 1'b1);
    settle();

    // survive_min out of range, then a width change in the middle of a grid
    set_reg(llars_pkg::REG_SURVIVE_MIN, llars_pkg::CFG_DATA_W'(15));
    set_reg(llars_pkg::REG_BIRTH_COUNT, llars_pkg::CFG_DATA_W'(llars_pkg::BIRTH_COUNT_RST));
    send_row({$urandom, $urandom}, 1'b0);
    settle();
    set_reg(llars_pkg::REG_GRID_WIDTH, llars_pkg::CFG_DATA_W'(33));
    send_row({$urandom, $urandom}, 1'b0);
    send_row({$urandom, $urandom}, 1'b1);
    settle();

    set_reg(llars_pkg::REG_GRID_WIDTH, llars_pkg::CFG_DATA_W'(llars_pkg::GRID_WIDTH_RST));
    set_reg(llars_pkg::REG_SURVIVE_MIN, llars_pkg::CFG_DATA_W'(llars_pkg::SURVIVE_MIN_RST));
    set_reg(llars_pkg::REG_SURVIVE_MAX, llars_pkg::CFG_DATA_W'(llars_pkg::SURVIVE_MAX_RST));

    while (rows_sent < 1030) begin
      late     = rows_sent > 900;
      gaps_on  = !late && ($urandom_range(0, 3) != 0);
      stall_on = !late && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        settle();
        case ($urandom_range(0, 9))
          0:       set_reg(llars_pkg::REG_GRID_WIDTH, llars_pkg::CFG_DATA_W'(0));
          1:       set_reg(llars_pkg::REG_GRID_WIDTH,
                           llars_pkg::CFG_DATA_W'($urandom_range(65, 255)));
          2, 3, 4: set_reg(llars_pkg::REG_GRID_WIDTH,
                           llars_pkg::CFG_DATA_W'($urandom_range(1, 63)));
          default: set_reg(llars_pkg::REG_GRID_WIDTH, llars_pkg::CFG_DATA_W'(64));
        endcase
        if ($urandom_range(0, 4) == 0) begin
          set_reg(llars_pkg::REG_BIRTH_COUNT, llars_pkg::CFG_DATA_W'($urandom));
          set_reg(llars_pkg::REG_SURVIVE_MIN, llars_pkg::CFG_DATA_W'($urandom));
          set_reg(llars_pkg::REG_SURVIVE_MAX, llars_pkg::CFG_DATA_W'($urandom));
          set_reg(llars_pkg::CFG_INDEX_W'($urandom_range(4, 255)),
                  llars_pkg::CFG_DATA_W'($urandom));
        end else begin
          lo = $urandom_range(0, 8);
          set_reg(llars_pkg::REG_BIRTH_COUNT, llars_pkg::CFG_DATA_W'($urandom_range(1, 8)));
          set_reg(llars_pkg::REG_SURVIVE_MIN, llars_pkg::CFG_DATA_W'(lo));
          set_reg(llars_pkg::REG_SURVIVE_MAX, llars_pkg::CFG_DATA_W'($urandom_range(lo, 8)));
        end
      end
      height = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      for (int r = 0; r < height; r++) begin
        if (height > 2 && r == height / 2 && $urandom_range(0, 15) == 0) begin
          settle();
          set_reg(llars_pkg::REG_GRID_WIDTH, llars_pkg::CFG_DATA_W'($urandom_range(1, 64)));
        end
        case ($urandom_range(0, 11))
          0:       cells = '0;
          1:       cells = '1;
          2, 3:    cells = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
          4:       cells = {$urandom, $urandom} | {$urandom, $urandom};
          default: cells = {$urandom, $urandom};
        endcase
        send_row(cells, r == height - 1);
      end
    end

    gaps_on  = 1'b0;
    stall_on = 1'b0;
    settle();
    repeat (10) @(negedge clk);
    if (board.errors == 0 && board.pending_rows.size() == 0) begin
      $display("life_like_automaton_row_step_top_test OK");
    end else begin
      $display("life_like_automaton_row_step_top_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("life_like_automaton_row_step_top_test NOT OK");
    $finish;
  end

endmodule
